@@ hdl/bpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;
   localparam int POOL_BITS_DEF = 32768;
   localparam int MAX_RUN_DEF   = 64;
   localparam int WORD_BITS     = 64;
   localparam int PAGE_W        = 20;
   localparam int LIM_W         = 16;
   localparam int CNT_W         = 7;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOVIR = 2'd1;
   localparam logic [1:0] ST_NOPHY = 2'd2;
   localparam logic [1:0] ST_BAD   = 2'd3;

   localparam logic FUNC_RUN = 1'b0;
   localparam logic FUNC_FIX = 1'b1;

   localparam logic [2:0] REG_KVBASE = 3'd0;
   localparam logic [2:0] REG_UVBASE = 3'd1;
   localparam logic [2:0] REG_KPBASE = 3'd2;
   localparam logic [2:0] REG_UPBASE = 3'd3;
   localparam logic [2:0] REG_KPAGES = 3'd4;
   localparam logic [2:0] REG_UPAGES = 3'd5;
   localparam logic [2:0] REG_UVPAGE = 3'd6;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_VRD, S_VSCAN, S_MRD, S_VMARK, S_PRD, S_PSCAN, S_PEMIT,
      S_ERR
   } state_type;
endpackage

@@ hdl/bpa_map_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_map_ram: one bitmap memory, 64-bit words, registered read
// ----------------------------------------------------------------------------
module bpa_map_ram import bpa_pkg::*; #(
   parameter int WORDS = 512
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic [$clog2(WORDS)-1:0]     waddr,
   input  logic [WORD_BITS-1:0]         wdata,
   input  logic [$clog2(WORDS)-1:0]     raddr,
   output logic [WORD_BITS-1:0]         rdata
);
   logic [WORD_BITS-1:0] mem [WORDS];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

@@ hdl/bitmap_page_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator: first-fit bitmap page allocator
// Scans virtual and physical bitmaps held in word memories.
// ----------------------------------------------------------------------------
// A request is taken when req_start is high and busy is low. func 0 asks for
// a run of req_page_count virtual pages, func 1 for the single page
// req_virt_page. Each result appears for one cycle with rsp_valid; rsp_last
// marks the final result of a request. The receiver cannot stall.
// After reset a clearing pass writes zero to every bitmap word, one word per
// cycle, with busy high; csr writes are taken at any time. The virtual scan
// reads one 64-bit word and then checks one bit per cycle of that word;
// marking a run sets the bit of each page in turn, and each page then scans
// the physical map from frame zero, one bit per cycle after each word read.
// Each result is issued from the emit state and shows on the ports in the
// cycle after. A bad request goes straight to the error state, whose result
// is registered onto the ports. busy drops while the last result is on the
// ports; the bit-serial walk through the word memories sets the rate.
// Pool limits above POOL_BITS are clamped.
// ----------------------------------------------------------------------------
module bitmap_page_allocator import bpa_pkg::*; #(
   parameter int POOL_BITS = POOL_BITS_DEF,
   parameter int MAX_RUN   = MAX_RUN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   output logic              busy,
   input  logic              req_func,
   input  logic              req_pool,
   input  logic [CNT_W-1:0]  req_page_count,
   input  logic [PAGE_W-1:0] req_virt_page,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [PAGE_W-1:0] rsp_virt_page_res,
   output logic [PAGE_W-1:0] rsp_phys_page,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   localparam int WORDS = (POOL_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BI_W  = $clog2(POOL_BITS + 1) + 1;
   localparam int PB_W  = $clog2(WORD_BITS);

   // configuration registers
   logic [PAGE_W-1:0] kvbase_ff, uvbase_ff, kpbase_ff, upbase_ff;
   logic [LIM_W-1:0]  kpages_ff, upages_ff, uvpages_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         kvbase_ff  <= PAGE_W'(786688);
         uvbase_ff  <= '0;
         kpbase_ff  <= PAGE_W'(512);
         upbase_ff  <= PAGE_W'(512);
         kpages_ff  <= '0;
         upages_ff  <= '0;
         uvpages_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_KVBASE: kvbase_ff  <= csr_wdata[PAGE_W-1:0];
            REG_UVBASE: uvbase_ff  <= csr_wdata[PAGE_W-1:0];
            REG_KPBASE: kpbase_ff  <= csr_wdata[PAGE_W-1:0];
            REG_UPBASE: upbase_ff  <= csr_wdata[PAGE_W-1:0];
            REG_KPAGES: kpages_ff  <= csr_wdata[LIM_W-1:0];
            REG_UPAGES: upages_ff  <= csr_wdata[LIM_W-1:0];
            REG_UVPAGE: uvpages_ff <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [BI_W-1:0] clamp(input logic [LIM_W-1:0] n);
      logic [BI_W-1:0] w;
      begin
         w = BI_W'(n);
         clamp = (w > BI_W'(POOL_BITS)) ? BI_W'(POOL_BITS) : w;
      end
   endfunction

   // request registers
   state_type state_ff, state_in;
   logic              kern_ff;
   logic              func_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PAGE_W-1:0] vp_ff;
   logic [BI_W-1:0]   vlim_ff, plim_ff;
   logic [PAGE_W-1:0] vbase_ff, pbase_ff;
   logic [BI_W-1:0]   bit_ff, bit_in;     // scan position
   logic [CNT_W-1:0]  run_ff, run_in;     // free run length
   logic [BI_W-1:0]   start_ff, start_in; // run start
   logic [CNT_W-1:0]  k_ff, k_in;         // pages done / marked
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [1:0]        est_ff, est_in;
   logic [WA_W-1:0]   clr_ff;

   // two memories per side: index by pool
   logic [WA_W-1:0]      v_ra, p_ra, v_wa, p_wa;
   logic [WORD_BITS-1:0] v_wd, p_wd, kv_rd, uv_rd, kp_rd, up_rd, v_rd, p_rd;
   logic                 v_we, p_we, clr_we;

   bpa_map_ram #(.WORDS(WORDS)) u_kv (.clock, .we(clr_we || (kern_ff && v_we)),
      .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(kv_rd));
   bpa_map_ram #(.WORDS(WORDS)) u_uv (.clock, .we(clr_we || (!kern_ff && v_we)),
      .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(uv_rd));
   bpa_map_ram #(.WORDS(WORDS)) u_kp (.clock, .we(clr_we || (kern_ff && p_we)),
      .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(kp_rd));
   bpa_map_ram #(.WORDS(WORDS)) u_up (.clock, .we(clr_we || (!kern_ff && p_we)),
      .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(up_rd));

   assign v_rd = kern_ff ? kv_rd : uv_rd;
   assign p_rd = kern_ff ? kp_rd : up_rd;
   assign clr_we = (state_ff == S_CLEAR);

   logic [PB_W-1:0]      bpos;
   logic                 cur;
   logic [BI_W-1:0]      mbit;
   logic [WORD_BITS-1:0] mark_word;
   assign bpos = bit_ff[PB_W-1:0];
   assign cur  = word_ff[bpos];
   assign mbit = start_ff + BI_W'(k_ff);
   assign mark_word = word_ff | (WORD_BITS'(1) << mbit[PB_W-1:0]);

   logic accept;
   logic [PAGE_W-1:0] fidx;
   assign accept = req_start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign fidx = req_virt_page - (req_pool ? kvbase_ff : uvbase_ff);

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      bit_in = bit_ff; run_in = run_ff; start_in = start_ff; k_in = k_ff;
      word_in = word_ff; est_in = est_ff;
      v_ra = '0; p_ra = '0;
      v_we = 1'b0; p_we = 1'b0; v_wa = '0; p_wa = '0; v_wd = '0; p_wd = '0;
      case (state_ff)
         S_CLEAR: if (clr_ff == WA_W'(WORDS - 1)) state_in = S_IDLE;
         S_IDLE: begin
            // fetch the first word while the request is taken
            if (accept && req_func == FUNC_FIX) v_ra = WA_W'(fidx >> PB_W);
         end
         S_VRD: begin
            // word of current bit is being read
            state_in = S_VSCAN;
            word_in = v_rd;
         end
         S_VSCAN: begin
            if (func_ff == FUNC_FIX) begin
               // fixed page: set bit and go to frame search
               v_we = 1'b1; v_wa = WA_W'(bit_ff >> PB_W);
               v_wd = word_ff | (WORD_BITS'(1) << bpos);
               bit_in = '0; state_in = S_PRD; k_in = '0;
            end else if (bit_ff >= vlim_ff) begin
               est_in = ST_NOVIR; state_in = S_ERR;
            end else if (cur) begin
               run_in = '0; bit_in = bit_ff + 1'b1;
               if (&bpos) begin
                  state_in = S_VRD; v_ra = WA_W'(bit_in >> PB_W);
               end
            end else begin
               run_in = run_ff + 1'b1;
               if (run_ff + 1'b1 == cnt_ff) begin
                  start_in = bit_ff + 1'b1 - BI_W'(cnt_ff);
                  k_in = '0; state_in = S_MRD;
                  v_ra = WA_W'(start_in >> PB_W);
               end else begin
                  bit_in = bit_ff + 1'b1;
                  if (&bpos) begin
                     state_in = S_VRD; v_ra = WA_W'(bit_in >> PB_W);
                  end
               end
            end
         end
         S_MRD: begin
            // word holding the next run bit is being read
            state_in = S_VMARK;
            word_in = v_rd;
         end
         S_VMARK: begin
            // read-modify-write of each run word, one bit per cycle
            word_in = mark_word;
            v_we = 1'b1; v_wa = WA_W'(mbit >> PB_W); v_wd = mark_word;
            k_in = k_ff + 1'b1;
            if (k_ff + 1'b1 == cnt_ff) begin
               state_in = S_PRD; bit_in = '0; k_in = '0;
            end else if (&mbit[PB_W-1:0]) begin
               state_in = S_MRD; v_ra = WA_W'((mbit + 1'b1) >> PB_W);
            end
         end
         S_PRD: begin
            state_in = S_PSCAN; word_in = p_rd;
         end
         S_PSCAN: begin
            if (bit_ff >= plim_ff) begin
               est_in = ST_NOPHY; state_in = S_ERR;
            end else if (!cur) begin
               p_we = 1'b1; p_wa = WA_W'(bit_ff >> PB_W);
               p_wd = word_ff | (WORD_BITS'(1) << bpos);
               state_in = S_PEMIT;
            end else begin
               bit_in = bit_ff + 1'b1;
               if (&bpos) begin state_in = S_PRD; p_ra = WA_W'(bit_in >> PB_W); end
            end
         end
         S_PEMIT: begin
            k_in = k_ff + 1'b1;
            bit_in = '0;
            if (func_ff == FUNC_FIX || k_ff + 1'b1 == cnt_ff) state_in = S_IDLE;
            else state_in = S_PRD;
         end
         S_ERR: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (clr_we) begin
         v_we = 1'b1; p_we = 1'b1; v_wa = clr_ff; p_wa = clr_ff;
      end
   end

   // output generation
   logic              rv_in, rl_in;
   logic [1:0]        rs_in;
   logic [PAGE_W-1:0] rvp_in, rpp_in;
   logic              rv_ff, rl_ff;
   logic [1:0]        rs_ff;
   logic [PAGE_W-1:0] rvp_ff, rpp_ff;
   always_comb begin
      rv_in = 1'b0; rl_in = 1'b1; rs_in = ST_OK; rvp_in = '0; rpp_in = '0;
      case (state_ff)
         S_PEMIT: begin
            rv_in = 1'b1;
            rl_in = (func_ff == FUNC_FIX) || (k_ff + 1'b1 == cnt_ff);
            rvp_in = (func_ff == FUNC_FIX) ? vp_ff
                   : vbase_ff + PAGE_W'(start_ff) + PAGE_W'(k_ff);
            rpp_in = pbase_ff + PAGE_W'(bit_ff);
         end
         S_ERR: begin rv_in = 1'b1; rs_in = est_ff; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; rv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
         if (clr_we) clr_ff <= clr_ff + 1'b1;
         if (accept) begin
            if (req_func == FUNC_RUN &&
                (req_page_count == '0 || req_page_count > CNT_W'(MAX_RUN))) begin
               est_ff <= ST_BAD; state_ff <= S_ERR;
            end else if (req_func == FUNC_FIX &&
                fidx >= PAGE_W'(req_pool ? clamp(kpages_ff) : clamp(uvpages_ff))) begin
               est_ff <= ST_BAD; state_ff <= S_ERR;
            end else begin
               state_ff <= S_VRD;
               est_ff <= est_in;
            end
         end else begin
            state_ff <= state_in;
            est_ff <= est_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rl_ff <= rl_in; rs_ff <= rs_in; rvp_ff <= rvp_in; rpp_ff <= rpp_in;
      if (accept) begin
         kern_ff <= req_pool; func_ff <= req_func; cnt_ff <= req_page_count;
         vp_ff <= req_virt_page;
         vbase_ff <= req_pool ? kvbase_ff : uvbase_ff;
         pbase_ff <= req_pool ? kpbase_ff : upbase_ff;
         vlim_ff <= req_pool ? clamp(kpages_ff) : clamp(uvpages_ff);
         plim_ff <= req_pool ? clamp(kpages_ff) : clamp(upages_ff);
         bit_ff <= (req_func == FUNC_FIX) ? BI_W'(fidx) : '0;
         run_ff <= '0; k_ff <= '0; start_ff <= '0; word_ff <= '0;
      end else begin
         bit_ff <= bit_in; run_ff <= run_in; start_ff <= start_in;
         k_ff <= k_in; word_ff <= word_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_virt_page_res = rvp_ff;
   assign rsp_phys_page = rpp_ff;
   assign rsp_last = rl_ff;

   // checks
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last) else $error("error without last");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_phys_page == '0)
      else $error("error with page");
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == S_CLEAR) |-> !rsp_valid) else $error("result during clear");
endmodule

@@ dv/tb_bitmap_page_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator: self-checking bench for the bitmap page allocator
// A directed table of requests, then random requests over several pool
// settings, checked against an in-bench copy of the four bitmaps.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator import bpa_pkg::*; ();

   typedef struct {
      logic [1:0]        status;
      logic [PAGE_W-1:0] virt;
      logic [PAGE_W-1:0] phys;
      logic              last;
   } grant_type;

   typedef struct {
      logic              func;
      logic              pool;
      logic [CNT_W-1:0]  cnt;
      logic [PAGE_W-1:0] vp;
      bit                typed;
      grant_type         want;
   } alloc_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_start = 1'b0;
   logic              busy;
   logic              req_func = 1'b0;
   logic              req_pool = 1'b0;
   logic [CNT_W-1:0]  req_page_count = '0;
   logic [PAGE_W-1:0] req_virt_page = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [PAGE_W-1:0] rsp_virt_page_res;
   logic [PAGE_W-1:0] rsp_phys_page;
   logic              rsp_last;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [31:0]       csr_wdata = '0;

   bitmap_page_allocator dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mirrored allocator state, index 1 is the kernel side
   bit                virt_used [2][POOL_BITS_DEF];
   bit                phys_used [2][POOL_BITS_DEF];
   logic [PAGE_W-1:0] virt_base [2] = '{20'd0, 20'd786688};
   logic [PAGE_W-1:0] phys_base [2] = '{20'd512, 20'd512};
   logic [LIM_W-1:0]  kern_pages = '0;
   logic [LIM_W-1:0]  user_pages = '0;
   logic [LIM_W-1:0]  user_vpages = '0;

   grant_type predicted [$];
   grant_type pending_grants [$];
   int     mismatches = 0;
   bit     no_gaps = 0;

   function automatic int clamp_pages(logic [LIM_W-1:0] n);
      return (n > POOL_BITS_DEF) ? POOL_BITS_DEF : int'(n);
   endfunction

   function automatic int virt_limit(logic kern);
      return clamp_pages(kern ? kern_pages : user_vpages);
   endfunction

   function automatic int phys_limit(logic kern);
      return clamp_pages(kern ? kern_pages : user_pages);
   endfunction

   // first-fit search for n free bits among the first lim
   function automatic int first_free_run(bit is_virt, logic kern, int lim, int n);
      int run = 0;
      for (int i = 0; i < lim; i++) begin
         if (is_virt ? virt_used[kern][i] : phys_used[kern][i]) begin
            run = 0;
         end else begin
            run++;
            if (run == n) return i + 1 - n;
         end
      end
      return -1;
   endfunction

   function automatic int take_frame(logic kern);
      int f = first_free_run(1'b0, kern, phys_limit(kern), 1);
      if (f >= 0) phys_used[kern][f] = 1'b1;
      return f;
   endfunction

   function automatic void add_grant(logic [1:0] st, logic [PAGE_W-1:0] v,
                                     logic [PAGE_W-1:0] p, logic lst);
      grant_type g;
      g.status = st;
      g.virt   = v;
      g.phys   = p;
      g.last   = lst;
      predicted.push_back(g);
   endfunction

   // works out the grants of one request and updates the bitmaps
   function automatic void predict_alloc(logic func, logic kern,
                                         logic [CNT_W-1:0] cnt,
                                         logic [PAGE_W-1:0] vp);
      int start;
      int f;
      logic [PAGE_W-1:0] idx;
      predicted.delete();
      if (func == FUNC_RUN) begin
         if (cnt == 0 || cnt > MAX_RUN_DEF) begin
            add_grant(ST_BAD, '0, '0, 1'b1);
            return;
         end
         start = first_free_run(1'b1, kern, virt_limit(kern), int'(cnt));
         if (start < 0) begin
            add_grant(ST_NOVIR, '0, '0, 1'b1);
            return;
         end
         for (int k = 0; k < cnt; k++) virt_used[kern][start + k] = 1'b1;
         for (int k = 0; k < cnt; k++) begin
            f = take_frame(kern);
            if (f < 0) begin
               add_grant(ST_NOPHY, '0, '0, 1'b1);
               return;
            end
            add_grant(ST_OK, virt_base[kern] + PAGE_W'(start + k),
                      phys_base[kern] + PAGE_W'(f), (k + 1 == cnt));
         end
      end else begin
         idx = vp - virt_base[kern];
         if (idx >= virt_limit(kern)) begin
            add_grant(ST_BAD, '0, '0, 1'b1);
            return;
         end
         virt_used[kern][idx] = 1'b1;
         f = take_frame(kern);
         if (f < 0) add_grant(ST_NOPHY, '0, '0, 1'b1);
         else add_grant(ST_OK, vp, phys_base[kern] + PAGE_W'(f), 1'b1);
      end
   endfunction

   function automatic void apply_csr(logic [2:0] idx, logic [31:0] data);
      case (idx)
         REG_KVBASE: virt_base[1] = data[PAGE_W-1:0];
         REG_UVBASE: virt_base[0] = data[PAGE_W-1:0];
         REG_KPBASE: phys_base[1] = data[PAGE_W-1:0];
         REG_UPBASE: phys_base[0] = data[PAGE_W-1:0];
         REG_KPAGES: kern_pages = data[LIM_W-1:0];
         REG_UPAGES: user_pages = data[LIM_W-1:0];
         REG_UVPAGE: user_vpages = data[LIM_W-1:0];
         default: ;
      endcase
   endfunction

   // entered at a rising edge; leaves csr_valid high for a following write
   task automatic csr_write(logic [2:0] idx, logic [31:0] value, bit junk);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= junk ? {12'($urandom_range(1, 4095)), value[PAGE_W-1:0]} : value;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, junk ? {12'd1, value[PAGE_W-1:0]} : value);
   endtask

   task automatic write_all(logic [PAGE_W-1:0] kvb, logic [PAGE_W-1:0] uvb,
                            logic [PAGE_W-1:0] kpb, logic [PAGE_W-1:0] upb,
                            int kp, int up, int uvp);
      bit junk = ($urandom_range(0, 1) == 1);
      csr_write(REG_KVBASE, 32'(kvb), junk);
      csr_write(REG_UVBASE, 32'(uvb), junk);
      csr_write(REG_KPBASE, 32'(kpb), junk);
      csr_write(REG_UPBASE, 32'(upb), 1'b0);
      csr_write(REG_KPAGES, 32'(kp), 1'b0);
      csr_write(REG_UPAGES, 32'(up), 1'b0);
      csr_write(REG_UVPAGE, 32'(uvp), 1'b0);
      csr_valid <= 1'b0;
   endtask

   // let every outstanding grant arrive and the block settle
   task automatic drain;
      req_start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic int pick_gap;
      int r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // entered at a rising edge; req_start stays high after acceptance
   task automatic send_request(alloc_row_type row);
      int gap = pick_gap();
      if (gap > 0) begin
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_start      <= 1'b1;
      req_func       <= row.func;
      req_pool       <= row.pool;
      req_page_count <= row.cnt;
      req_virt_page  <= row.vp;
      do @(posedge clock); while (busy);
      predict_alloc(row.func, row.pool, row.cnt, row.vp);
      if (row.typed) pending_grants.push_back(row.want);
      else foreach (predicted[i]) pending_grants.push_back(predicted[i]);
   endtask

   function automatic alloc_row_type mk(logic func, logic pool, int cnt, int vp,
                                        bit typed = 0, logic [1:0] st = ST_OK,
                                        int v = 0, int p = 0);
      alloc_row_type r;
      r.func        = func;
      r.pool        = pool;
      r.cnt         = CNT_W'(cnt);
      r.vp          = PAGE_W'(vp);
      r.typed       = typed;
      r.want.status = st;
      r.want.virt   = PAGE_W'(v);
      r.want.phys   = PAGE_W'(p);
      r.want.last   = 1'b1;
      return r;
   endfunction

   function automatic alloc_row_type random_row;
      alloc_row_type r;
      int lim;
      int sel = $urandom_range(0, 99);
      r = mk(FUNC_RUN, $urandom_range(0, 1), 1, $urandom);
      lim = virt_limit(r.pool);
      if (sel < 8) begin
         r.cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(65, 127);
      end else if (sel < 33) begin
         r.func = FUNC_FIX;
         if ($urandom_range(0, 4) != 0)
            r.vp = virt_base[r.pool] + PAGE_W'($urandom_range(0, lim + 4));
      end else begin
         sel = $urandom_range(0, 99);
         if (sel < 85) r.cnt = $urandom_range(1, 8);
         else if (sel < 97) r.cnt = $urandom_range(9, 32);
         else r.cnt = $urandom_range(33, 64);
      end
      return r;
   endfunction

   // grant checker, the receiver never stalls
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected grant: st=%0d v=%h p=%h last=%b", rsp_status,
                        rsp_virt_page_res, rsp_phys_page, rsp_last);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_status !== want.status || rsp_virt_page_res !== want.virt ||
                rsp_phys_page !== want.phys || rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"grant mismatch: exp st=%0d v=%h p=%h last=%b, ",
                            "got st=%0d v=%h p=%h last=%b"},
                           want.status, want.virt, want.phys, want.last, rsp_status,
                           rsp_virt_page_res, rsp_phys_page, rsp_last);
            end
         end
      end
   end

   initial begin
      #100ms;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      alloc_row_type directed [$];
      int phase_items [6] = '{70, 70, 70, 60, 40, 80};
      int kp;
      int up;
      int uvp;
      // pools all empty after reset
      directed.push_back(mk(FUNC_RUN, 0, 1, 0, 1, ST_NOVIR));
      directed.push_back(mk(FUNC_RUN, 1, 64, 0, 1, ST_NOVIR));
      directed.push_back(mk(FUNC_RUN, 0, 0, 0, 1, ST_BAD));
      directed.push_back(mk(FUNC_RUN, 1, 65, 0, 1, ST_BAD));
      directed.push_back(mk(FUNC_RUN, 0, 127, 0, 1, ST_BAD));
      directed.push_back(mk(FUNC_FIX, 0, 1, 0, 1, ST_BAD));
      directed.push_back(mk(FUNC_FIX, 1, 0, 'hFFFFF, 1, ST_BAD));
      // small pools, kernel bases wrap past the top of the page space
      directed.push_back(mk(FUNC_RUN, 1, 1, 0, 1, ST_OK, 'hFFFF0, 'hFFFFE));
      directed.push_back(mk(FUNC_FIX, 1, 0, 'hFFFF1));
      directed.push_back(mk(FUNC_FIX, 1, 0, 'h00000));
      directed.push_back(mk(FUNC_FIX, 1, 0, 'hFFFEF, 1, ST_BAD));
      directed.push_back(mk(FUNC_FIX, 1, 0, 'h0001F));
      directed.push_back(mk(FUNC_FIX, 1, 0, 'h00020, 1, ST_BAD));
      directed.push_back(mk(FUNC_FIX, 1, 0, 'hFFFF1));
      directed.push_back(mk(FUNC_RUN, 1, 64, 0, 1, ST_NOVIR));
      directed.push_back(mk(FUNC_RUN, 0, 64, 0));
      directed.push_back(mk(FUNC_RUN, 0, 1, 0));
      directed.push_back(mk(FUNC_RUN, 1, 40, 0));
      directed.push_back(mk(FUNC_FIX, 0, 0, 'h00100));
      directed.push_back(mk(FUNC_FIX, 0, 0, 'hFFFFF, 1, ST_BAD));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (i == 7) begin
            drain();
            write_all('hFFFF0, 'h00100, 'hFFFFE, 'h00000, 48, 12, 80);
         end
         send_request(directed[i]);
      end

      // random phases, limits mostly grow so fresh bits stay available
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: begin kp = 128; up = 96; uvp = 160; end
            1: begin kp = 256; up = 300; uvp = 200; end
            2: begin kp = 512; up = 512; uvp = 512; end
            3: begin kp = 0; up = 0; uvp = 0; end
            4: begin kp = 65535; up = 32768; uvp = 40000; end
            default: begin kp = 700; up = 700; uvp = 700; end
         endcase
         if (ph == 2)
            write_all('h00000, 'hFFFFF, 'hFFFFF, 'h00000, kp, up, uvp);
         else if (ph == 3)
            write_all('hFFFFF, 'hFFFFF, 'h00000, 'hFFFFF, kp, up, uvp);
         else
            write_all($urandom, $urandom, $urandom, $urandom, kp, up, uvp);
         no_gaps = (ph == 1 || ph == 4);
         repeat (phase_items[ph]) send_request(random_row());
      end

      drain();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_grants.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
